// ===== rtl/ocrp_pkg.sv =====
// Shared types, character codes and field/error codes for the OHLC record parser.
`default_nettype none

package ocrp_pkg;

    localparam int FIELD_W = 4;
    localparam int VALUE_W = 64;
    localparam int ERR_W   = 2;
    localparam int CC_W    = 5;
    localparam int FRAC_W  = 4;
    localparam int BYTE_W  = 8;

    // Largest number of kept fraction digits; one scaled copy of the accumulator per step.
    localparam int FD_MAX = 9;
    localparam int NSCALE = FD_MAX + 1;
    localparam int SC_IW  = $clog2(NSCALE);

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

    // Field ids
    localparam logic [FIELD_W-1:0] FID_TICKER = 4'd0;
    localparam logic [FIELD_W-1:0] FID_PERIOD = 4'd1;
    localparam logic [FIELD_W-1:0] FID_DATE   = 4'd2;
    localparam logic [FIELD_W-1:0] FID_TIME   = 4'd3;
    localparam logic [FIELD_W-1:0] FID_OPEN   = 4'd4;
    localparam logic [FIELD_W-1:0] FID_HIGH   = 4'd5;
    localparam logic [FIELD_W-1:0] FID_LOW    = 4'd6;
    localparam logic [FIELD_W-1:0] FID_CLOSE  = 4'd7;
    localparam logic [FIELD_W-1:0] FID_VOLUME = 4'd8;
    localparam logic [FIELD_W-1:0] FID_OI     = 4'd9;

    // Error kinds
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TICKER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PERIOD = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EOL    = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] field_id;
        logic [VALUE_W-1:0] value;
        logic [ERR_W-1:0]   error_kind;
        logic               last;
    } result_t;

    // Up to two results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

    function automatic result_t make_result(input logic [FIELD_W-1:0] fid,
                                            input logic [VALUE_W-1:0] val,
                                            input logic [ERR_W-1:0]   err,
                                            input logic               lst);
        result_t r;
        r.field_id   = fid;
        r.value      = val;
        r.error_kind = err;
        r.last       = lst;
        return r;
    endfunction

    // 10^k for k = 0..9
    function automatic logic [29:0] pow10(input int k);
        logic [29:0] p;
        case (k)
            0:       p = 30'd1;
            1:       p = 30'd10;
            2:       p = 30'd100;
            3:       p = 30'd1000;
            4:       p = 30'd10000;
            5:       p = 30'd100000;
            6:       p = 30'd1000000;
            7:       p = 30'd10000000;
            8:       p = 30'd100000000;
            9:       p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ocrp_input_reg.sv =====
// Input register holding one accepted byte until the parser steps on it.
`default_nettype none

module ocrp_input_reg
    import ocrp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              room,
    output logic                   step,
    output logic [BYTE_W-1:0]      byte_out,
    output logic                   start_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              start_reg;
    logic              load;

    // the held byte moves on whenever the queue can take two results
    assign step     = valid_reg && room;
    assign s_tready = !valid_reg || step;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    assign byte_out  = byte_reg;
    assign start_out = start_reg;

endmodule

`default_nettype wire

// ===== rtl/ocrp_parse.sv =====
// Record parser state and per-byte result logic.
`default_nettype none

module ocrp_parse
    import ocrp_pkg::*;
#(
    parameter int TICKER_LIMIT = 20
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              file_start,
    input  wire logic [FRAC_W-1:0] fd,
    output result_pair_t           res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PARSE,
        PH_EOL,
        PH_DISCARD
    } phase_t;

    localparam logic [CC_W-1:0] TICK_LIM = CC_W'(TICKER_LIMIT);
    localparam logic [CC_W-1:0] PER_LIM  = CC_W'(2);

    phase_t             phase_reg, phase_next;
    logic [FIELD_W-1:0] fid_reg, fid_next;
    logic [VALUE_W-1:0] scale_reg [NSCALE];
    logic [VALUE_W-1:0] scale_next [NSCALE];
    logic [CC_W-1:0]    cc_reg, cc_next;
    logic               pp_reg, pp_next;
    logic [BYTE_W-1:0]  period_reg, period_next;

    // state after an optional new-file restart
    phase_t             ph_e;
    logic [FIELD_W-1:0] fi_e;
    logic [VALUE_W-1:0] sc_e [NSCALE];
    logic [CC_W-1:0]    cc_e;
    logic               pp_e;

    logic signed [8:0]  dig;
    logic signed [39:0] term [NSCALE];
    logic [VALUE_W-1:0] sc_mac [NSCALE];
    logic [CC_W-1:0]    cc_inc;
    logic [SC_IW-1:0]   pad_idx;
    logic [VALUE_W-1:0] price_val;
    logic               is_sep;
    result_pair_t       res_c;

    assign dig    = $signed({1'b0, in_byte}) - $signed({1'b0, CH_ZERO});
    assign cc_inc = cc_e + 1'b1;
    assign is_sep = in_byte inside {CH_COMMA, CH_CR, CH_LF};

    // scale_reg[k] always holds accumulator * 10^k, so padding is a select
    always_comb begin
        for (int k = 0; k < NSCALE; k++) begin
            sc_e[k] = file_start ? '0 : scale_reg[k];
            term[k] = dig * $signed({1'b0, pow10(k)});
            sc_mac[k] = (sc_e[k] << 3) + (sc_e[k] << 1)
                      + {{(VALUE_W-40){term[k][39]}}, term[k]};
        end
    end

    assign ph_e = file_start ? PH_HEADER : phase_reg;
    assign fi_e = file_start ? FID_TICKER : fid_reg;
    assign cc_e = file_start ? '0 : cc_reg;
    assign pp_e = file_start ? 1'b0 : pp_reg;

    always_comb begin
        pad_idx   = SC_IW'(fd - cc_e[FRAC_W-1:0]);
        price_val = ({1'b0, fd} > cc_e) ? sc_e[pad_idx] : sc_e[0];
    end

    always_comb begin
        phase_next  = ph_e;
        fid_next    = fi_e;
        cc_next     = cc_e;
        pp_next     = pp_e;
        period_next = period_reg;
        for (int k = 0; k < NSCALE; k++) begin
            scale_next[k] = sc_e[k];
        end
        res_c.count = 2'd0;
        res_c.r0    = make_result(fi_e, '0, ERR_NONE, 1'b0);
        res_c.r1    = make_result(fi_e, '0, ERR_NONE, 1'b0);

        case (ph_e)
            PH_HEADER, PH_EOL: begin
                if (in_byte == CH_LF) begin
                    phase_next = PH_PARSE;
                    fid_next   = FID_TICKER;
                    cc_next    = '0;
                    pp_next    = 1'b0;
                    for (int k = 0; k < NSCALE; k++) begin
                        scale_next[k] = '0;
                    end
                end
            end
            PH_PARSE: begin
                case (fi_e)
                    FID_TICKER: begin
                        if (in_byte == CH_COMMA) begin
                            fid_next = fi_e + 1'b1;
                            cc_next  = '0;
                            pp_next  = 1'b0;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = '0;
                            end
                        end else if (in_byte == CH_LF) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, '0, ERR_EOL, 1'b1);
                            phase_next  = PH_DISCARD;
                        end else begin
                            res_c.r0 = make_result(FID_TICKER, VALUE_W'(in_byte),
                                                   ERR_NONE, 1'b0);
                            cc_next  = cc_inc;
                            if (cc_inc >= TICK_LIM) begin
                                res_c.count = 2'd2;
                                res_c.r1    = make_result(fi_e, '0, ERR_TICKER, 1'b1);
                                phase_next  = PH_DISCARD;
                            end else begin
                                res_c.count = 2'd1;
                            end
                        end
                    end
                    FID_PERIOD: begin
                        if (in_byte == CH_COMMA) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(FID_PERIOD, VALUE_W'(period_reg),
                                                      ERR_NONE, 1'b0);
                            fid_next    = fi_e + 1'b1;
                            cc_next     = '0;
                            pp_next     = 1'b0;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = '0;
                            end
                        end else if (in_byte == CH_LF) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, '0, ERR_EOL, 1'b1);
                            phase_next  = PH_DISCARD;
                        end else begin
                            period_next = in_byte;
                            cc_next     = cc_inc;
                            if (cc_inc >= PER_LIM) begin
                                res_c.count = 2'd1;
                                res_c.r0    = make_result(fi_e, '0, ERR_PERIOD, 1'b1);
                                phase_next  = PH_DISCARD;
                            end
                        end
                    end
                    FID_DATE, FID_TIME: begin
                        if (in_byte == CH_COMMA) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, sc_e[0], ERR_NONE, 1'b0);
                            fid_next    = fi_e + 1'b1;
                            cc_next     = '0;
                            pp_next     = 1'b0;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = '0;
                            end
                        end else if (in_byte == CH_LF) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, '0, ERR_EOL, 1'b1);
                            phase_next  = PH_DISCARD;
                        end else begin
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = sc_mac[k];
                            end
                        end
                    end
                    FID_OPEN, FID_HIGH, FID_LOW, FID_CLOSE: begin
                        if (in_byte == CH_COMMA) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, price_val, ERR_NONE, 1'b0);
                            fid_next    = fi_e + 1'b1;
                            cc_next     = '0;
                            pp_next     = 1'b0;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = '0;
                            end
                        end else if (in_byte == CH_LF) begin
                            res_c.count = 2'd1;
                            res_c.r0    = make_result(fi_e, '0, ERR_EOL, 1'b1);
                            phase_next  = PH_DISCARD;
                        end else if (!pp_e) begin
                            if (in_byte == CH_POINT) begin
                                pp_next = 1'b1;
                            end else begin
                                for (int k = 0; k < NSCALE; k++) begin
                                    scale_next[k] = sc_mac[k];
                                end
                            end
                        end else if (cc_e < CC_W'(fd)) begin
                            // fraction digits beyond fd are dropped
                            cc_next = cc_inc;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = sc_mac[k];
                            end
                        end
                    end
                    FID_VOLUME, FID_OI: begin
                        if (is_sep) begin
                            if (fi_e == FID_VOLUME) begin
                                res_c.r0 = make_result(FID_VOLUME, sc_e[0], ERR_NONE, 1'b0);
                            end else begin
                                res_c.r0 = make_result(FID_OI, sc_e[0], ERR_NONE, 1'b1);
                            end
                            cc_next = '0;
                            pp_next = 1'b0;
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = '0;
                            end
                            if (fi_e == FID_VOLUME && in_byte == CH_COMMA) begin
                                res_c.count = 2'd1;
                                fid_next    = fi_e + 1'b1;
                            end else begin
                                if (fi_e == FID_VOLUME) begin
                                    // open interest missing: report it as zero
                                    res_c.count = 2'd2;
                                    res_c.r1    = make_result(FID_OI, '0, ERR_NONE, 1'b1);
                                end else begin
                                    res_c.count = 2'd1;
                                end
                                if (in_byte == CH_LF) begin
                                    phase_next = PH_PARSE;
                                    fid_next   = FID_TICKER;
                                end else begin
                                    phase_next = PH_EOL;
                                end
                            end
                        end else if (in_byte == CH_POINT) begin
                            pp_next = 1'b1;
                        end else if (!pp_e) begin
                            for (int k = 0; k < NSCALE; k++) begin
                                scale_next[k] = sc_mac[k];
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_DISCARD;
                    end
                endcase
            end
            PH_DISCARD: begin
                phase_next = PH_DISCARD;
            end
            default: begin
                phase_next = PH_DISCARD;
            end
        endcase
    end

    always_comb begin
        res = res_c;
        if (!step) begin
            res.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            fid_reg    <= FID_TICKER;
            cc_reg     <= '0;
            pp_reg     <= 1'b0;
            period_reg <= '0;
            for (int k = 0; k < NSCALE; k++) begin
                scale_reg[k] <= '0;
            end
        end else if (step) begin
            phase_reg  <= phase_next;
            fid_reg    <= fid_next;
            cc_reg     <= cc_next;
            pp_reg     <= pp_next;
            period_reg <= period_next;
            for (int k = 0; k < NSCALE; k++) begin
                scale_reg[k] <= scale_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ocrp_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none

module ocrp_out_fifo
    import ocrp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire result_pair_t push,
    input  wire logic         m_ready,
    output logic              m_valid,
    output result_t           head,
    output logic              room
);

    result_t          mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic [OQ_AW-1:0] wr_ptr_inc;
    logic             pop;

    assign m_valid    = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign room       = (count_reg <= OQ_CW'(OQ_DEPTH - 2));
    assign pop        = m_valid && m_ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OQ_CW'(push.count) - OQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_inc] <= push.r1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OQ_CW'(OQ_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |=> m_valid)
        else $error("pushed result not visible");

endmodule

`default_nettype wire

// ===== rtl/ohlc_csv_record_parser_core.sv =====
// Top level of the OHLC quote file record parser.
`default_nettype none

// Streams one byte of a comma-separated quote file per s_ transfer (tuser
// flags the first byte of a file) and emits one m_ transfer per parsed value.
// The header line of each file is skipped; each record gives the ticker bytes
// (field 0), the period character (1), date and time (2, 3), four prices as
// fixed point scaled by 10^frac_digits (4..7, frac_digits above nine acts as
// nine), volume (8) and open interest (9, tlast). An error result (tlast set,
// value zero, kind in tuser) stops the parse until the next file start.
// Rate: one byte per cycle while the queue has room. An accepted byte sits in
// the input register until it is parsed, and its results are then written into a
// four-entry queue, so a byte passes the input register and then the queue
// before its first result is on m_. A byte may yield two results (ticker
// overflow, volume ending the line), and the queue drains one result per
// cycle, so the sustained byte rate is bounded by m_tready and by these
// double-result bytes; the input stalls only while fewer than two queue
// entries are free. The frac_digits register may be written at any idle time.
module ohlc_csv_record_parser_core
    import ocrp_pkg::*;
#(
    parameter int TICKER_LIMIT = 20
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input byte stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,      // [7:0] in_byte
    input  wire logic                s_tuser,      // [0] file_start
    // parsed values
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [VALUE_W-1:0]       m_tdata,      // [63:0] value
    output logic [FIELD_W+ERR_W-1:0] m_tuser,      // [3:0] field_id, [5:4] error_kind
    output logic                     m_tlast,      // last
    // frac_digits register
    input  wire logic                cfg_wr_en,
    input  wire logic [FRAC_W-1:0]   cfg_wr_data
);

    logic [FRAC_W-1:0] frac_digits_reg;
    logic [FRAC_W-1:0] fd_eff;
    logic              room;
    logic              step;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_start;
    result_pair_t      results;
    result_t           head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_digits_reg <= FRAC_W'(4);
        end else if (cfg_wr_en) begin
            frac_digits_reg <= cfg_wr_data;
        end
    end

    // clamp: more than nine fraction digits are treated as nine
    assign fd_eff = (frac_digits_reg > FRAC_W'(FD_MAX)) ? FRAC_W'(FD_MAX) : frac_digits_reg;

    ocrp_input_reg u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .room      (room),
        .step      (step),
        .byte_out  (cur_byte),
        .start_out (cur_start)
    );

    ocrp_parse #(
        .TICKER_LIMIT (TICKER_LIMIT)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .in_byte    (cur_byte),
        .file_start (cur_start),
        .fd         (fd_eff),
        .res        (results)
    );

    ocrp_out_fifo u_oq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (results),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .head    (head),
        .room    (room)
    );

    assign m_tdata = head.value;
    assign m_tuser = {head.error_kind, head.field_id};
    assign m_tlast = head.last;

    // every error result closes its run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.error_kind != ERR_NONE) |-> m_tlast)
        else $error("error result without tlast");

    // field ids stay within the record layout
    a_fid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head.field_id <= FID_OI))
        else $error("field id out of range");

    // an error never carries a value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.error_kind != ERR_NONE) |-> (head.value == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire
